// ----- sv/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Scrolling text console package
// Shared sizes, codes, request types and the character mapping function.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 32;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;
	localparam int CELL_W      = 7;
	localparam int CCOLS_W     = 7;
	localparam int CROWS_W     = 6;
	localparam int CFG_W       = 7;

	localparam logic [CELL_W-1:0] SPACE   = 7'h20;
	localparam logic [CELL_W-1:0] QMARK   = 7'h3F;
	localparam logic [7:0]        NEWLINE = 8'h0A;
	localparam logic [7:0]        FIRST_PRINTABLE = 8'h20;

	localparam logic [CCOLS_W-1:0] COLS_RESET = 7'd32;
	localparam logic [CROWS_W-1:0] ROWS_RESET = 6'd16;

	typedef enum logic [1:0] {
		CMD_TEXT  = 2'd0,
		CMD_EOL   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_COLUMNS = 1'b0,
		CFG_ROWS    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	function automatic logic [CELL_W-1:0] map_char(input logic [7:0] c);
		logic [CELL_W-1:0] r;
		if (c < FIRST_PRINTABLE) begin
			r = SPACE;
		end else if (c[7]) begin
			r = QMARK;
		end else begin
			r = c[CELL_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/stc_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Console command channel
// Valid/ready channel that carries one console command word.
// ----------------------------------------------------------------------------
interface stc_cmd_if;
	logic                       valid;
	logic                       ready;
	stc_pkg::cmd_t              command;
	logic [7:0]                 char_code;
	logic [stc_pkg::ROW_W-1:0]  read_row;
	logic [stc_pkg::COL_W-1:0]  read_column;

	modport source (output valid, command, char_code, read_row, read_column, input ready);
	modport sink   (input valid, command, char_code, read_row, read_column, output ready);
endinterface

// ----- sv/stc_cell_if.sv -----
// ----------------------------------------------------------------------------
// Console cell result channel
// Valid/ready channel that carries one cell read result word.
// ----------------------------------------------------------------------------
interface stc_cell_if;
	logic                       valid;
	logic                       ready;
	logic [stc_pkg::CELL_W-1:0] cell_char;
	logic                       cell_valid;

	modport source (output valid, cell_char, cell_valid, input ready);
	modport sink   (input valid, cell_char, cell_valid, output ready);
endinterface

// ----- sv/stc_cell_ram.sv -----
// ----------------------------------------------------------------------------
// Console cell memory
// One write port and one registered read port over the character grid.
// ----------------------------------------------------------------------------
module stc_cell_ram (
	input  logic                       clk,
	input  stc_pkg::ram_wr_t           wr,
	input  stc_pkg::ram_rd_t           rd,
	output logic [stc_pkg::CELL_W-1:0] rd_data
);
	import stc_pkg::*;

	logic [CELL_W-1:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- sv/stc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Console sequencer
// Cursor, ring offset and configuration state, plus the sweep counter that
// clears the grid or blanks one row a cell per cycle.
// ----------------------------------------------------------------------------
module stc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  stc_pkg::cfg_idx_t          cfg_index,
	input  logic [stc_pkg::CFG_W-1:0]  cfg_data,
	stc_cmd_if.sink                    cmd,
	stc_cell_if.source                 rsp,
	output stc_pkg::ram_wr_t           ram_wr,
	output stc_pkg::ram_rd_t           ram_rd,
	input  logic [stc_pkg::CELL_W-1:0] ram_rd_data
);
	import stc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CLEAR  = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_READ   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [CCOLS_W-1:0]  cols_q;
	logic [CROWS_W-1:0]  rows_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    top_q;
	logic                disc_q;
	logic [ROW_W-1:0]    scroll_row_q;
	logic                rd_ok_q;
	logic                out_valid_q;
	logic [CELL_W-1:0]   out_char_q;
	logic                out_cvalid_q;

	logic [CCOLS_W-1:0]  eff_cols;
	logic [CROWS_W-1:0]  eff_rows;
	logic [ADDR_W-1:0]   cnt_inc;
	logic [CCOLS_W-1:0]  col_inc;
	logic [CROWS_W-1:0]  row_inc;
	logic                col_wrap;
	logic                row_over;
	logic [ROW_W-1:0]    last_row;
	logic [ROW_W-1:0]    top_inc;
	logic [ROW_W-1:0]    scroll_phys;
	logic [ROW_W-1:0]    cur_phys;
	logic [ROW_W-1:0]    rd_phys;
	logic                in_screen;
	logic                rd_ok;
	logic                accept;
	logic                do_text;
	logic                do_eol;
	logic                need_row;
	logic                need_scroll;
	logic                out_free;

	always_comb begin
		if (cols_q == '0) begin
			eff_cols = CCOLS_W'(1);
		end else if (cols_q > CCOLS_W'(MAX_COLUMNS)) begin
			eff_cols = CCOLS_W'(MAX_COLUMNS);
		end else begin
			eff_cols = cols_q;
		end
		if (rows_q == '0) begin
			eff_rows = CROWS_W'(1);
		end else if (rows_q > CROWS_W'(MAX_ROWS)) begin
			eff_rows = CROWS_W'(MAX_ROWS);
		end else begin
			eff_rows = rows_q;
		end
	end

	assign cnt_inc     = cnt_q + ADDR_W'(1);
	assign col_inc     = CCOLS_W'(col_q) + CCOLS_W'(1);
	assign row_inc     = CROWS_W'(row_q) + CROWS_W'(1);
	assign col_wrap    = col_inc >= eff_cols;
	assign row_over    = row_inc >= eff_rows;
	assign last_row    = ROW_W'(eff_rows - CROWS_W'(1));
	assign top_inc     = top_q + ROW_W'(1);
	assign scroll_phys = top_inc + last_row;
	assign cur_phys    = top_q + row_q;
	assign rd_phys     = top_q + cmd.read_row;
	assign in_screen   = (CROWS_W'(row_q) < eff_rows) && (CCOLS_W'(col_q) < eff_cols);
	assign rd_ok       = (CROWS_W'(cmd.read_row) < eff_rows)
		&& (CCOLS_W'(cmd.read_column) < eff_cols);

	assign cmd.ready   = (state_q == ST_IDLE);
	assign accept      = cmd.valid && cmd.ready;
	assign do_text     = accept && (cmd.command == CMD_TEXT) && !disc_q
		&& (cmd.char_code != NEWLINE);
	assign do_eol      = accept && (cmd.command == CMD_EOL);
	assign need_row    = do_eol || (do_text && col_wrap);
	assign need_scroll = need_row && row_over;
	assign out_free    = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_char  = out_char_q;
	assign rsp.cell_valid = out_cvalid_q;

	always_comb begin
		ram_wr.en   = 1'b0;
		ram_wr.addr = {cur_phys, col_q};
		ram_wr.data = SPACE;
		case (state_q)
			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cnt_q;
			end
			ST_SCROLL: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = {scroll_row_q, cnt_q[COL_W-1:0]};
			end
			default: begin
				ram_wr.en   = do_text && in_screen;
				ram_wr.data = map_char(cmd.char_code);
			end
		endcase
	end

	assign ram_rd.en   = accept && (cmd.command == CMD_READ);
	assign ram_rd.addr = {rd_phys, cmd.read_column};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			cols_q       <= COLS_RESET;
			rows_q       <= ROWS_RESET;
			row_q        <= '0;
			col_q        <= '0;
			top_q        <= '0;
			disc_q       <= 1'b0;
			scroll_row_q <= '0;
			rd_ok_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_char_q   <= SPACE;
			out_cvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLUMNS: cols_q <= cfg_data;
					CFG_ROWS:    rows_q <= cfg_data[CROWS_W-1:0];
					default:     ;
				endcase
			end
			if (rsp.valid && rsp.ready && (state_q != ST_READ)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.command == CMD_TEXT) && !disc_q
						&& (cmd.char_code == NEWLINE)) begin
						disc_q <= 1'b1;
					end
					if (do_text) begin
						col_q <= col_wrap ? '0 : col_inc[COL_W-1:0];
					end
					if (do_eol) begin
						disc_q <= 1'b0;
						col_q  <= '0;
					end
					if (need_row) begin
						row_q <= row_over ? last_row : row_inc[ROW_W-1:0];
					end
					if (need_scroll) begin
						top_q        <= top_inc;
						scroll_row_q <= scroll_phys;
						cnt_q        <= '0;
						state_q      <= ST_SCROLL;
					end
					if (accept && (cmd.command == CMD_CLEAR)) begin
						row_q   <= '0;
						col_q   <= '0;
						top_q   <= '0;
						disc_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_CLEAR;
					end
					if (ram_rd.en) begin
						rd_ok_q <= rd_ok;
						state_q <= ST_READ;
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_inc;
					if (cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_inc;
					if (cnt_q[COL_W-1:0] == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_char_q   <= rd_ok_q ? ram_rd_data : SPACE;
						out_cvalid_q <= rd_ok_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else if (rsp.valid && rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_read_enters_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.en |=> state_q == ST_READ)
		else $error("Accepted read did not enter the read wait state.");

	a_clear_ends_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) && (cnt_q == '1)
		|=> (state_q == ST_IDLE) && (row_q == '0) && (col_q == '0) && (top_q == '0))
		else $error("Clear sweep did not end idle with the cursor at home.");

	a_scroll_rotates: assert property (@(posedge clk) disable iff (!arst_n)
		need_scroll |=> (state_q == ST_SCROLL) && (top_q == $past(top_inc)))
		else $error("Scroll did not rotate the ring and start the row sweep.");

	a_read_port_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !ram_rd.en)
		else $error("Read port was reused while a read word was pending.");

endmodule

// ----- sv/scrolling_text_console_core.sv -----
// A read word is registered out of the cell memory, then into the output register;
// a read holds off the input until the word is loaded there, longer while the previous
// read word still waits. A text byte or end of line that scrolls holds off the input
// while the new bottom row is blanked one cell per cycle through the write port.
// Clear blanks every cell, and after reset a clearing pass runs during which no
// command is taken. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// Scrolling text console core
// Character grid with line wrap, scroll-up, clear and cell read-back.
// ----------------------------------------------------------------------------
module scrolling_text_console_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  stc_pkg::cfg_idx_t          cfg_index,
	input  logic [stc_pkg::CFG_W-1:0]  cfg_data,
	stc_cmd_if.sink                    cmd,
	stc_cell_if.source                 rsp
);
	import stc_pkg::*;

	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [CELL_W-1:0] ram_rd_data;

	stc_cell_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_rd_data)
	);

	stc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.rsp         (rsp),
		.ram_wr      (ram_wr),
		.ram_rd      (ram_rd),
		.ram_rd_data (ram_rd_data)
	);

endmodule
